>>> rtl/stbs_pkg.sv
// ----------------------------------------------------------------------------
// stbs_pkg: shared definitions for the sorted table binary search core
// Field widths, item kind codes and the register reset value.
// ----------------------------------------------------------------------------
package stbs_pkg;

  localparam int unsigned IdxW   = 10;  // entry_index and position
  localparam int unsigned KeyInW = 32;  // key_value on the input channel
  localparam int unsigned SizeW  = 11;  // table_size register

  localparam logic [SizeW-1:0] SizeReset = 11'd1024;

  typedef enum logic {
    KindWrite  = 1'b0,
    KindSearch = 1'b1
  } kind_e;

endpackage

>>> rtl/stbs_if.sv
// ----------------------------------------------------------------------------
// stbs_if: channel interfaces of the sorted table binary search core
// Input item, result item and table size write channels, valid/ready each.
// ----------------------------------------------------------------------------
interface stbs_in_if;
  import stbs_pkg::*;

  logic                     valid;
  logic                     ready;
  kind_e                    kind;
  logic [IdxW-1:0]          entry_index;
  logic signed [KeyInW-1:0] key_value;

  modport source (output valid, kind, entry_index, key_value, input ready);
  modport sink   (input valid, kind, entry_index, key_value, output ready);
endinterface

interface stbs_out_if;
  import stbs_pkg::*;

  logic            valid;
  logic            ready;
  logic            found;
  logic [IdxW-1:0] position;

  modport source (output valid, found, position, input ready);
  modport sink   (input valid, found, position, output ready);
endinterface

interface stbs_cfg_if;
  import stbs_pkg::*;

  logic             valid;
  logic             ready;
  logic [SizeW-1:0] table_size;

  modport source (output valid, table_size, input ready);
  modport sink   (input valid, table_size, output ready);
endinterface

>>> rtl/stbs_ram.sv
// ----------------------------------------------------------------------------
// stbs_ram: key table storage
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module stbs_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/sorted_table_binary_search.sv
// ----------------------------------------------------------------------------
// sorted_table_binary_search_core: binary search over a descending key table
// Loads table entries by write items and answers search items with a found
// flag and the matching position.
// ----------------------------------------------------------------------------
// A write item lands in the key RAM at its transfer and leaves the block
// idle and ready, so writes are taken back to back. A search item reads
// entry 0 and then the last live entry for the range check, then does one
// RAM read per halving step, and then moves its result into the output
// register. A key outside the table's range ends after the two bound reads;
// a table size of zero ends at once. The single RAM read port, with its
// registered read data, sets the pace of the halving loop. The result waits
// in an output register, so write items are taken while it is not yet
// collected; a second search stalls only in StDone until that register
// frees up. No clearing pass: entries are undefined until written.
module sorted_table_binary_search_core #(
  parameter int unsigned ENTRIES   = 1024,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  stbs_in_if.sink    in_i,
  stbs_out_if.source out_o,
  stbs_cfg_if.sink   cfg_i
);
  import stbs_pkg::*;

  localparam int unsigned AddrW   = $clog2(ENTRIES);
  localparam int unsigned FillW   = $clog2(ENTRIES + 1);
  // range bounds hold the saturated size and the 10-bit write index
  localparam int unsigned CntW    = (FillW > SizeW) ? FillW : SizeW;
  localparam int unsigned KeyCopy = (KEY_WIDTH < KeyInW) ? KEY_WIDTH : KeyInW;

  localparam logic [CntW-1:0] EntriesC = CntW'(ENTRIES);

  typedef enum logic [2:0] {
    StIdle,
    StFirst,  // entry 0 on the read port
    StLast,   // last live entry on the read port
    StStep,   // entry at mid on the read port
    StDone
  } state_e;

  state_e              state_q, state_d;
  logic [SizeW-1:0]    cfg_size_q, cfg_size_d;
  logic [CntW-1:0]     size_q, size_d;
  logic [KEY_WIDTH-1:0] key_q, key_d;
  logic [CntW-1:0]     lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic                in_range_q, in_range_d;
  logic                res_found_q, res_found_d;
  logic [IdxW-1:0]     res_pos_q, res_pos_d;
  logic                out_valid_q, out_valid_d;
  logic                out_found_q, out_found_d;
  logic [IdxW-1:0]     out_pos_q, out_pos_d;

  // RAM port signals
  logic                 ram_we;
  logic [AddrW-1:0]     ram_waddr, ram_raddr;
  logic [KEY_WIDTH-1:0] ram_rdata;

  // Helpers
  logic                 in_xfer, cfg_xfer, out_xfer;
  logic [KEY_WIDTH-1:0] key_ext;
  logic [CntW-1:0]      idx_ext, size_ext, size_sat, last_idx;
  logic [CntW-1:0]      step_lo, step_hi, mid_first, mid_step;
  logic [CntW:0]        sum_first, sum_step;
  logic                 key_gt, key_lt;

  assign in_xfer  = in_i.valid && in_i.ready;
  assign cfg_xfer = cfg_i.valid && cfg_i.ready;
  assign out_xfer = out_o.valid && out_o.ready;

  assign in_i.ready     = (state_q == StIdle);
  assign cfg_i.ready    = 1'b1;
  assign out_o.valid    = out_valid_q;
  assign out_o.found    = out_found_q;
  assign out_o.position = out_pos_q;

  // Key: low bits of the input word, zero above bit 31 for wide tables.
  always_comb begin
    key_ext = '0;
    key_ext[KeyCopy-1:0] = in_i.key_value[KeyCopy-1:0];
  end

  assign idx_ext  = CntW'(in_i.entry_index);
  assign size_ext = CntW'(cfg_size_q);
  assign size_sat = (size_ext > EntriesC) ? EntriesC : size_ext;
  assign last_idx = size_q - CntW'(1);

  // Table writes happen only in idle, never during a search: no
  // read/write overlap on the RAM to forward around.
  assign ram_we    = in_xfer && (in_i.kind == KindWrite) && (idx_ext < EntriesC);
  assign ram_waddr = idx_ext[AddrW-1:0];

  // Signed order compare of the searched key against the entry read.
  assign key_gt = $signed(key_q) > $signed(ram_rdata);
  assign key_lt = $signed(key_q) < $signed(ram_rdata);

  // First midpoint: lo = 0, hi = size.
  assign sum_first = {1'b0, size_q} - (CntW + 1)'(1);
  assign mid_first = sum_first[CntW:1];

  // Halving step: narrow the range around mid.
  assign step_lo  = key_lt ? (mid_q + CntW'(1)) : lo_q;
  assign step_hi  = key_gt ? mid_q : hi_q;
  assign sum_step = {1'b0, step_lo} + {1'b0, step_hi} - (CntW + 1)'(1);
  assign mid_step = sum_step[CntW:1];

  always_comb begin
    state_d     = state_q;
    cfg_size_d  = cfg_size_q;
    size_d      = size_q;
    key_d       = key_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    in_range_d  = in_range_q;
    res_found_d = res_found_q;
    res_pos_d   = res_pos_q;
    out_valid_d = out_valid_q && !out_xfer;
    out_found_d = out_found_q;
    out_pos_d   = out_pos_q;
    ram_raddr   = mid_q[AddrW-1:0];

    if (cfg_xfer) begin
      cfg_size_d = cfg_i.table_size;
    end

    case (state_q)
      StIdle: begin
        ram_raddr = '0;
        if (in_xfer && (in_i.kind == KindSearch)) begin
          key_d       = key_ext;
          size_d      = size_sat;
          res_found_d = 1'b0;
          res_pos_d   = '0;
          state_d     = (size_sat == '0) ? StDone : StFirst;
        end
      end
      StFirst: begin
        ram_raddr  = last_idx[AddrW-1:0];
        in_range_d = !key_gt;
        state_d    = StLast;
      end
      StLast: begin
        ram_raddr = mid_first[AddrW-1:0];
        lo_d      = '0;
        hi_d      = size_q;
        mid_d     = mid_first;
        state_d   = (in_range_q && !key_lt) ? StStep : StDone;
      end
      StStep: begin
        ram_raddr = mid_step[AddrW-1:0];
        if (!key_gt && !key_lt) begin
          res_found_d = 1'b1;
          res_pos_d   = mid_q[IdxW-1:0];
          state_d     = StDone;
        end else if (step_lo < step_hi) begin
          lo_d  = step_lo;
          hi_d  = step_hi;
          mid_d = mid_step;
        end else begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_found_d = res_found_q;
          out_pos_d   = res_pos_q;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cfg_size_q  <= SizeReset;
      out_valid_q <= 1'b0;
      size_q      <= '0;
      key_q       <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      mid_q       <= '0;
      in_range_q  <= 1'b0;
      res_found_q <= 1'b0;
      res_pos_q   <= '0;
      out_found_q <= 1'b0;
      out_pos_q   <= '0;
    end else begin
      state_q     <= state_d;
      cfg_size_q  <= cfg_size_d;
      out_valid_q <= out_valid_d;
      size_q      <= size_d;
      key_q       <= key_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      mid_q       <= mid_d;
      in_range_q  <= in_range_d;
      res_found_q <= res_found_d;
      res_pos_q   <= res_pos_d;
      out_found_q <= out_found_d;
      out_pos_q   <= out_pos_d;
    end
  end

  stbs_ram #(
    .DEPTH (ENTRIES),
    .WIDTH (KEY_WIDTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (key_ext),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

>>> rtl/stbs_checker.sv
// ----------------------------------------------------------------------------
// stbs_checker: port-level assertions for the binary search core
// Watches the top-level channels; bound to every core instance.
// ----------------------------------------------------------------------------
module stbs_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      in_kind_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic                      out_found_i,
  input logic [stbs_pkg::IdxW-1:0] out_position_i
);
  import stbs_pkg::*;

  // a search occupies the block: no transfer on the next cycle
  a_search_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && in_kind_i == KindSearch) |=> !in_ready_i)
    else $error("input ready right after a search transfer");

  // write items never produce a result
  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && in_kind_i == KindWrite && !out_valid_i)
      |=> !out_valid_i)
    else $error("result appeared after a write item");

  // a miss reports position zero
  a_miss_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_found_i) |-> (out_position_i == '0))
    else $error("not-found result with nonzero position");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i)
      |=> (out_valid_i && $stable(out_found_i) && $stable(out_position_i)))
    else $error("stalled result changed");

endmodule

bind sorted_table_binary_search_core stbs_checker u_stbs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .in_kind_i      (in_i.kind),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_found_i    (out_o.found),
  .out_position_i (out_o.position)
);

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for sorted_table_binary_search_core
// Loads descending key tables through write items, fires searches at them and
// checks every found/position result against an in-bench search predictor.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import stbs_pkg::*;

  localparam int unsigned Entries       = 1024;
  localparam int unsigned SearchLatency = 14;
  localparam int unsigned DrainPause    = 20;    // covers a trailing write
  localparam int unsigned HoldCycles    = 400;   // long receiver hold-off
  localparam int unsigned WatchdogLimit = 5000;  // cycles without a transfer
  localparam int unsigned MaxReports    = 10;

  localparam logic signed [KeyInW-1:0] KeyMax = {1'b0, {(KeyInW-1){1'b1}}};
  localparam logic signed [KeyInW-1:0] KeyMin = {1'b1, {(KeyInW-1){1'b0}}};

  typedef struct packed {
    kind_e                    kind;
    logic [IdxW-1:0]          entry_index;
    logic signed [KeyInW-1:0] key_value;
  } table_op_t;

  typedef struct packed {
    logic            found;
    logic [IdxW-1:0] position;
  } search_result_t;

  logic clk_i;
  logic rst_ni;

  stbs_in_if  in_ch ();
  stbs_out_if out_ch ();
  stbs_cfg_if cfg_ch ();

  sorted_table_binary_search_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  // 20 ns clock
  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Every block input known from time zero.
  initial begin
    rst_ni             = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.kind         = KindWrite;
    in_ch.entry_index  = '0;
    in_ch.key_value    = '0;
    out_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.table_size  = '0;
  end

  // --------------------------------------------------------------------------
  // Shared bookkeeping
  // --------------------------------------------------------------------------
  table_op_t      pending_ops[$];     // stimulus not yet offered
  search_result_t expected_hits[$];   // one entry per accepted search
  int unsigned    queued_ops;         // pushed by the generator
  int unsigned    accepted_ops;       // counted by the monitor
  int unsigned    mismatches;
  int unsigned    stall_cycles;
  int unsigned    send_idle_pct;
  int unsigned    recv_idle_pct;
  int unsigned    hold_requests;
  int unsigned    hold_served;
  int unsigned    hold_left;
  bit             in_fire;

  // Predictor state: its own copy of the key RAM and the size register.
  logic signed [KeyInW-1:0] model_keys [Entries];
  int unsigned              model_size;

  // Generator mirror, updated in queue order so it matches model_keys at the
  // time each queued search is accepted.
  logic signed [KeyInW-1:0] stim_keys [Entries];

  initial begin
    queued_ops    = 0;
    accepted_ops  = 0;
    mismatches    = 0;
    stall_cycles  = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests = 0;
    hold_served   = 0;
    hold_left     = 0;
    in_fire       = 1'b0;
    model_size    = SizeReset;
  end

  // --------------------------------------------------------------------------
  // Search predictor: range check against entry 0 and the last live entry,
  // then halve [lo, hi) with the lower midpoint until a hit or an empty range.
  // Sizes above the RAM depth saturate; a size of zero never reads the RAM.
  // --------------------------------------------------------------------------
  function automatic search_result_t search_table(logic signed [KeyInW-1:0] key);
    search_result_t res;
    int unsigned    live;
    int unsigned    lo;
    int unsigned    hi;
    int unsigned    mid;
    res.found    = 1'b0;
    res.position = '0;
    live = (model_size > Entries) ? Entries : model_size;
    if (live != 0 && key <= model_keys[0] && key >= model_keys[live-1]) begin
      lo = 0;
      hi = live;
      while (lo < hi) begin
        mid = (lo + hi - 1) / 2;
        if (key > model_keys[mid]) begin
          hi = mid;
        end else if (key < model_keys[mid]) begin
          lo = mid + 1;
        end else begin
          res.found    = 1'b1;
          res.position = IdxW'(mid);
          break;
        end
      end
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Input driver: offers the next pending op at the falling edge, holds it
  // until its transfer, idles at the current sender rate.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    table_op_t op;
    if (rst_ni && (!in_ch.valid || in_fire)) begin
      if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        op = pending_ops.pop_front();
        in_ch.valid       <= 1'b1;
        in_ch.kind        <= op.kind;
        in_ch.entry_index <= op.entry_index;
        in_ch.key_value   <= op.key_value;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result receiver: random back-pressure, plus long hold-offs on request.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left    = hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served  = hold_served + 1;
      hold_left    = HoldCycles;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: samples all three channels at the rising edge, runs the
  // predictor on accepted input ops and checks each result transfer.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    search_result_t want;
    bit             progress;
    progress = 1'b0;
    in_fire  = in_ch.valid && in_ch.ready;
    if (in_fire) begin
      progress     = 1'b1;
      accepted_ops = accepted_ops + 1;
      if (in_ch.kind == KindWrite) begin
        model_keys[in_ch.entry_index] = in_ch.key_value;
      end else begin
        expected_hits.push_back(search_table(in_ch.key_value));
      end
    end
    if (out_ch.valid && out_ch.ready) begin
      progress = 1'b1;
      if (expected_hits.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= MaxReports)
          $display("%0t: result with no search pending: found=%0b position=%0d",
                   $realtime, out_ch.found, out_ch.position);
      end else begin
        want = expected_hits.pop_front();
        if (out_ch.found !== want.found || out_ch.position !== want.position) begin
          mismatches = mismatches + 1;
          if (mismatches <= MaxReports)
            $display("%0t: result mismatch: found exp %0b got %0b, position exp %0d got %0d",
                     $realtime, want.found, out_ch.found, want.position, out_ch.position);
        end
      end
    end
    if (cfg_ch.valid && cfg_ch.ready) begin
      progress   = 1'b1;
      model_size = cfg_ch.table_size;
    end
    stall_cycles = progress ? 0 : stall_cycles + 1;
  end

  // Watchdog: too long without any transfer on any channel.
  initial begin
    wait (stall_cycles >= WatchdogLimit);
    $display("Verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_write(int unsigned idx, logic signed [KeyInW-1:0] key);
    table_op_t op;
    op.kind        = KindWrite;
    op.entry_index = IdxW'(idx);
    op.key_value   = key;
    stim_keys[idx] = key;
    pending_ops.push_back(op);
    queued_ops = queued_ops + 1;
  endtask

  task automatic push_search(logic signed [KeyInW-1:0] key);
    table_op_t op;
    op.kind        = KindSearch;
    op.entry_index = IdxW'($urandom);  // don't-care field, toggled anyway
    op.key_value   = key;
    pending_ops.push_back(op);
    queued_ops = queued_ops + 1;
  endtask

  // Sender pause: returns once every queued op is accepted and every
  // expected result has been collected.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (accepted_ops != queued_ops || expected_hits.size() != 0);
  endtask

  // Size register is only touched with the block idle; the pause covers a
  // write op still in flight after the last result.
  task automatic write_table_size(int unsigned value);
    wait_drained();
    repeat (DrainPause) @(negedge clk_i);
    cfg_ch.table_size <= SizeW'(value);
    cfg_ch.valid      <= 1'b1;
    do @(posedge clk_i);
    while (!cfg_ch.ready);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  // One random phase: set the size, optionally reload a fresh descending
  // table over the live range, then a mix of searches and writes. Most
  // writes keep the table ordered; a few land past the live range or are
  // plain noise that may break the order.
  task automatic gen_phase(int unsigned size_reg, int unsigned n_ops, bit refill);
    int unsigned              live;
    int unsigned              idx;
    int unsigned              pick;
    longint                   cur;
    longint                   step_max;
    longint                   lo_b;
    longint                   hi_b;
    logic signed [KeyInW-1:0] key;
    live = (size_reg > Entries) ? Entries : size_reg;
    write_table_size(size_reg);
    if (refill && live != 0) begin
      step_max = 64'hFFFF_FFFF / (live + 1);
      if ($urandom_range(1) == 1) step_max = step_max / 1000 + 1;  // clustered
      cur = longint'(KeyMax) - longint'($urandom_range(32'(step_max)));
      for (int unsigned i = 0; i < live; i++) begin
        push_write(i, KeyInW'(cur));
        // occasional zero step gives runs of equal keys
        if ($urandom_range(9) != 0) cur = cur - longint'($urandom_range(32'(step_max)));
      end
    end
    for (int unsigned n = 0; n < n_ops; n++) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        pick = $urandom_range(99);
        if (live != 0 && pick < 55) begin
          key = stim_keys[$urandom_range(live - 1)];
        end else if (live != 0 && pick < 70) begin
          key = stim_keys[$urandom_range(live - 1)] - 1;
        end else if (live != 0 && pick < 80) begin
          key = $urandom_range(1) ? stim_keys[0] + 1 : stim_keys[live-1] - 1;
        end else if (pick < 88) begin
          key = $urandom_range(1) ? KeyMax : KeyMin;
        end else begin
          key = $urandom;
        end
        push_search(key);
      end else begin
        pick = $urandom_range(99);
        if (live != 0 && pick < 75) begin
          idx  = $urandom_range(live - 1);
          lo_b = (idx == live - 1) ? longint'(KeyMin) : longint'(stim_keys[idx+1]);
          hi_b = (idx == 0) ? longint'(KeyMax) : longint'(stim_keys[idx-1]);
          if (lo_b > hi_b) key = $urandom;
          else key = KeyInW'(lo_b + longint'($urandom_range(32'(hi_b - lo_b))));
          push_write(idx, key);
        end else if (live < Entries && pick < 90) begin
          push_write($urandom_range(Entries - 1, live), $urandom);
        end else begin
          push_write($urandom_range(Entries - 1), $urandom);
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    send_idle_pct = 15;
    recv_idle_pct = 88;

    // Directed: extreme keys at both ends, equal keys, in-range miss.
    write_table_size(5);
    push_write(0, KeyMax);
    push_write(1, 100);
    push_write(2, 7);
    push_write(3, 7);
    push_write(4, KeyMin);
    push_search(KeyMax);
    push_search(KeyMin);
    push_search(7);
    push_search(100);
    push_search(50);

    // Directed: keys above entry 0 and below the last live entry.
    write_table_size(3);
    push_write(0, 10);
    push_write(1, 0);
    push_write(2, -10);
    push_search(11);
    push_search(-11);
    push_search(0);

    // Directed: empty table.
    write_table_size(0);
    push_search(KeyMax);
    push_search(0);

    // Directed: single entry.
    write_table_size(1);
    push_write(0, 42);
    push_search(42);
    push_search(41);

    // Directed: table out of order.
    write_table_size(4);
    push_write(0, 3);
    push_write(1, 9);
    push_write(2, -4);
    push_write(3, 20);
    push_search(9);
    push_search(20);

    // Random, receiver mostly stalled. Oversized register saturates and
    // loads the whole RAM, so every later phase reads written entries only.
    gen_phase(2047, 30, 1'b1);
    gen_phase(1, 10, 1'b1);
    gen_phase(2, 10, 1'b1);
    gen_phase($urandom_range(64, 3), 20, 1'b1);

    // Random, sender mostly idle.
    send_idle_pct = 88;
    recv_idle_pct = 15;
    gen_phase(0, 10, 1'b0);
    gen_phase(1024, 30, 1'b0);
    gen_phase($urandom_range(64, 3), 20, 1'b1);
    gen_phase($urandom_range(64, 3), 20, 1'b1);

    // Random, no idling; one long receiver hold-off while ops keep coming,
    // so the output register fills and the input stalls.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    gen_phase(64, 20, 1'b1);
    hold_requests = hold_requests + 1;
    gen_phase(1023, 30, 1'b0);
    gen_phase($urandom_range(64, 3), 20, 1'b1);
    gen_phase(7, 10, 1'b1);

    wait_drained();
    repeat (2 * SearchLatency) @(negedge clk_i);
    if (mismatches == 0 && expected_hits.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
